[rtl/cht_pkg.sv]
package cht_pkg;

   localparam int KEY_W          = 34;
   localparam int TAG_W          = 64;
   localparam int STATUS_W       = 3;
   localparam int SLOT_W         = 4;
   localparam int CMP_W          = 5;
   localparam int TABLE_SIZE_DEF = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 3'd4;

   typedef struct packed {
      logic             opcode;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] name_tag;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [CMP_W-1:0]    comparisons;
      logic [TAG_W-1:0]    found_tag;
   } rsp_type;

   // per-field write enables of the slot memory
   typedef struct packed {
      logic wr_key;
      logic wr_tag;
      logic wr_link;
   } mem_we_type;

endpackage

[rtl/cht_home.sv]
// Remainder of a key by the table size, each step registered: per-group sums of the
// constant residues 2^i mod TABLE_SIZE of the set key bits, their total, then
// compare and subtract of shifted moduli until the total is below TABLE_SIZE.
module cht_home #(
   parameter int TABLE_SIZE = cht_pkg::TABLE_SIZE_DEF,
   localparam int IDX_W = $clog2(TABLE_SIZE)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [cht_pkg::KEY_W-1:0] value,
   output logic                     done,
   output logic [IDX_W-1:0]         rem
);
   import cht_pkg::*;

   localparam int GROUP_W   = 9;
   localparam int GROUPS    = (KEY_W + GROUP_W - 1) / GROUP_W;
   localparam int EXT_W     = GROUPS * GROUP_W;
   // a sum of fewer than 64 residues stays below 64 * TABLE_SIZE
   localparam int RED_STEPS = 6;
   localparam int SUM_W     = IDX_W + RED_STEPS;
   localparam logic [SUM_W-1:0] MODULUS = SUM_W'(TABLE_SIZE);

   typedef logic [EXT_W-1:0][IDX_W-1:0]  residue_type;
   typedef logic [GROUPS-1:0][SUM_W-1:0] part_type;

   function automatic residue_type bit_residues();
      residue_type r;
      longint      p;
      p = 1;
      for (int i = 0; i < EXT_W; i++) begin
         r[i] = IDX_W'(p);
         p    = (p * 2) % TABLE_SIZE;
      end
      return r;
   endfunction

   localparam residue_type RESIDUE = bit_residues();

   logic [EXT_W-1:0] value_ext;
   part_type         part_ff, part_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic             part_vld_ff;
   logic             sum_vld_ff;
   logic             done_ff;
   logic [SUM_W-1:0] red;

   always_comb begin
      value_ext = EXT_W'(value);

      part_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         for (int b = 0; b < GROUP_W; b++) begin
            if (value_ext[g * GROUP_W + b]) begin
               part_in[g] = part_in[g] + SUM_W'(RESIDUE[g * GROUP_W + b]);
            end
         end
      end

      sum_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         sum_in = sum_in + part_ff[g];
      end

      red = sum_ff;
      for (int j = RED_STEPS - 1; j >= 0; j--) begin
         if (red >= (MODULUS << j)) begin
            red = red - (MODULUS << j);
         end
      end

      rem_in = sum_vld_ff ? red[IDX_W-1:0] : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         part_vld_ff <= start;
         sum_vld_ff  <= part_vld_ff;
         done_ff     <= sum_vld_ff;
      end
      part_ff <= part_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !(part_vld_ff || sum_vld_ff))
      else $error("remainder unit restarted while busy");

endmodule

[rtl/cht_mem.sv]
// Single-port slot store: key, tag and link share one address, read-first,
// read data registered.
module cht_mem #(
   parameter int TABLE_SIZE = cht_pkg::TABLE_SIZE_DEF,
   localparam int IDX_W  = $clog2(TABLE_SIZE),
   localparam int LINK_W = $clog2(TABLE_SIZE + 1)
) (
   input  logic                      clock,
   input  logic [IDX_W-1:0]          addr,
   input  cht_pkg::mem_we_type       we,
   input  logic [cht_pkg::KEY_W-1:0] wkey,
   input  logic [cht_pkg::TAG_W-1:0] wtag,
   input  logic [LINK_W-1:0]         wlink,
   output logic [cht_pkg::KEY_W-1:0] rkey,
   output logic [cht_pkg::TAG_W-1:0] rtag,
   output logic [LINK_W-1:0]         rlink
);
   import cht_pkg::*;

   logic [KEY_W-1:0]  key_mem  [TABLE_SIZE];
   logic [TAG_W-1:0]  tag_mem  [TABLE_SIZE];
   logic [LINK_W-1:0] link_mem [TABLE_SIZE];

   logic [KEY_W-1:0]  rkey_ff;
   logic [TAG_W-1:0]  rtag_ff;
   logic [LINK_W-1:0] rlink_ff;

   always_ff @(posedge clock) begin
      if (we.wr_key) begin
         key_mem[addr] <= wkey;
      end
      if (we.wr_tag) begin
         tag_mem[addr] <= wtag;
      end
      if (we.wr_link) begin
         link_mem[addr] <= wlink;
      end
      rkey_ff  <= key_mem[addr];
      rtag_ff  <= tag_mem[addr];
      rlink_ff <= link_mem[addr];
   end

   assign rkey  = rkey_ff;
   assign rtag  = rtag_ff;
   assign rlink = rlink_ff;

endmodule

[rtl/cht_seq.sv]
// Sequencer: walks chains, probes, evicts and searches through the slot store.
// Every state that uses read data has driven its address in the cycle before;
// no state reads an address in the cycle it is written.
module cht_seq #(
   parameter int TABLE_SIZE = cht_pkg::TABLE_SIZE_DEF,
   localparam int IDX_W  = $clog2(TABLE_SIZE),
   localparam int LINK_W = $clog2(TABLE_SIZE + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      replace_mode,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cht_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cht_pkg::rsp_type          rsp_data,
   output logic [IDX_W-1:0]          mem_addr,
   output cht_pkg::mem_we_type       mem_we,
   output logic [cht_pkg::KEY_W-1:0] mem_wkey,
   output logic [cht_pkg::TAG_W-1:0] mem_wtag,
   output logic [LINK_W-1:0]         mem_wlink,
   input  logic [cht_pkg::KEY_W-1:0] mem_rkey,
   input  logic [cht_pkg::TAG_W-1:0] mem_rtag,
   input  logic [LINK_W-1:0]         mem_rlink,
   output logic                      mod_start,
   output logic [cht_pkg::KEY_W-1:0] mod_value,
   input  logic                      mod_done,
   input  logic [IDX_W-1:0]          mod_rem
);
   import cht_pkg::*;

   localparam int STEP_W = $clog2(TABLE_SIZE + 1);
   localparam int CNT_W  = $clog2(TABLE_SIZE + 2);

   localparam logic [LINK_W-1:0] NO_LINK   = LINK_W'(TABLE_SIZE);
   localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(TABLE_SIZE - 1);
   localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(TABLE_SIZE);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(TABLE_SIZE);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_HOME     = 4'd2;
   localparam logic [3:0] S_SRCH     = 4'd3;
   localparam logic [3:0] S_INS_HOME = 4'd4;
   localparam logic [3:0] S_EV_HOME  = 4'd5;
   localparam logic [3:0] S_PRED     = 4'd6;
   localparam logic [3:0] S_PUT_EV   = 4'd7;
   localparam logic [3:0] S_CI_ADDR  = 4'd8;
   localparam logic [3:0] S_CI_HOME  = 4'd9;
   localparam logic [3:0] S_WALK     = 4'd10;
   localparam logic [3:0] S_PROBE    = 4'd11;
   localparam logic [3:0] S_LINK     = 4'd12;
   localparam logic [3:0] S_DONE     = 4'd13;

   logic [3:0]          state_ff, state_in;
   logic [IDX_W-1:0]    a_ff, a_in;
   logic [IDX_W-1:0]    end_ff, end_in;
   logic [IDX_W-1:0]    home_ff, home_in;
   logic [IDX_W-1:0]    ih_ff, ih_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                op_ff, op_in;
   logic [KEY_W-1:0]    wk_ff, wk_in;
   logic [TAG_W-1:0]    wt_ff, wt_in;
   logic [KEY_W-1:0]    ek_ff, ek_in;
   logic [TAG_W-1:0]    et_ff, et_in;
   logic [LINK_W-1:0]   enext_ff, enext_in;
   logic                evict_ff, evict_in;
   logic [STEP_W-1:0]   fill_ff, fill_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_slot_ff, res_slot_in;
   logic [CNT_W-1:0]    res_cmp_ff, res_cmp_in;
   logic [TAG_W-1:0]    res_tag_ff, res_tag_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]    a_wrap;
   logic                link_live;

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      end_in        = end_ff;
      home_in       = home_ff;
      ih_in         = ih_ff;
      steps_in      = steps_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      wk_in         = wk_ff;
      wt_in         = wt_ff;
      ek_in         = ek_ff;
      et_in         = et_ff;
      enext_in      = enext_ff;
      evict_in      = evict_ff;
      fill_in       = fill_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_cmp_in    = res_cmp_ff;
      res_tag_in    = res_tag_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      mem_addr  = a_ff;
      mem_we    = '0;
      mem_wkey  = wk_ff;
      mem_wtag  = wt_ff;
      mem_wlink = NO_LINK;
      mod_start = 1'b0;
      mod_value = req_data.key;

      a_wrap    = (a_ff == LAST_SLOT) ? '0 : a_ff + IDX_W'(1);
      link_live = (mem_rlink < NO_LINK);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we.wr_key  = 1'b1;
            mem_we.wr_link = 1'b1;
            mem_wkey       = '0;
            a_in           = a_wrap;
            if (a_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            res_slot_in = '0;
            res_cmp_in  = '0;
            res_tag_in  = '0;
            evict_in    = 1'b0;
            if (req_valid) begin
               op_in = req_data.opcode;
               wk_in = req_data.key;
               wt_in = req_data.name_tag;
               if (req_data.key == '0) begin
                  res_status_in = ST_ZERO_KEY;
                  state_in      = S_DONE;
               end else if (req_data.opcode == OP_INSERT && fill_ff == STEP_MAX) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_HOME;
               end
            end
         end
         S_HOME: begin
            mem_addr = mod_rem;
            if (mod_done) begin
               home_in = mod_rem;
               a_in    = mod_rem;
               cnt_in  = CNT_W'(1);
               state_in = (op_ff == OP_SEARCH) ? S_SRCH : S_INS_HOME;
            end
         end
         S_SRCH: begin
            if (mem_rkey == wk_ff) begin
               res_status_in = ST_FOUND;
               res_slot_in   = a_ff;
               res_cmp_in    = cnt_ff;
               res_tag_in    = mem_rtag;
               state_in      = S_DONE;
            end else if (link_live && cnt_ff <= CNT_MAX) begin
               a_in     = IDX_W'(mem_rlink);
               mem_addr = IDX_W'(mem_rlink);
               cnt_in   = cnt_ff + CNT_W'(1);
            end else begin
               res_status_in = ST_NOT_FOUND;
               res_cmp_in    = cnt_ff;
               state_in      = S_DONE;
            end
         end
         S_INS_HOME: begin
            if (mem_rkey == '0) begin
               mem_addr       = home_ff;
               mem_we         = '1;
               res_status_in  = ST_INSERTED;
               res_slot_in    = home_ff;
               fill_in        = fill_ff + STEP_W'(1);
               state_in       = S_DONE;
            end else if (replace_mode) begin
               // occupant's own home decides whether it is foreign
               ek_in     = mem_rkey;
               et_in     = mem_rtag;
               enext_in  = mem_rlink;
               mod_start = 1'b1;
               mod_value = mem_rkey;
               state_in  = S_EV_HOME;
            end else begin
               ih_in    = home_ff;
               state_in = S_CI_ADDR;
            end
         end
         S_EV_HOME: begin
            mem_addr = '0;
            if (mod_done) begin
               ih_in = (mod_rem == home_ff) ? home_ff : mod_rem;
               a_in  = '0;
               state_in = (mod_rem == home_ff) ? S_CI_ADDR : S_PRED;
            end
         end
         S_PRED: begin
            // find the slot linking to the evicted entry and bypass it
            if (a_ff != home_ff && mem_rlink == LINK_W'(home_ff)) begin
               mem_we.wr_link = 1'b1;
               mem_wlink      = enext_ff;
               state_in       = S_PUT_EV;
            end else if (a_ff == LAST_SLOT) begin
               state_in = S_PUT_EV;
            end else begin
               a_in     = a_wrap;
               mem_addr = a_wrap;
            end
         end
         S_PUT_EV: begin
            mem_addr = home_ff;
            mem_we   = '1;
            wk_in    = ek_ff;
            wt_in    = et_ff;
            evict_in = 1'b1;
            state_in = S_CI_ADDR;
         end
         S_CI_ADDR: begin
            mem_addr = ih_ff;
            state_in = S_CI_HOME;
         end
         S_CI_HOME: begin
            mem_addr = ih_ff;
            if (mem_rkey == '0) begin
               mem_we        = '1;
               res_status_in = ST_INSERTED;
               res_slot_in   = evict_ff ? home_ff : ih_ff;
               fill_in       = fill_ff + STEP_W'(1);
               state_in      = S_DONE;
            end else begin
               a_in     = ih_ff;
               steps_in = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (link_live && steps_ff < STEP_MAX) begin
               a_in     = IDX_W'(mem_rlink);
               mem_addr = IDX_W'(mem_rlink);
               steps_in = steps_ff + STEP_W'(1);
            end else begin
               end_in   = a_ff;
               steps_in = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (mem_rkey != '0 && steps_ff < STEP_MAX) begin
               a_in     = a_wrap;
               mem_addr = a_wrap;
               steps_in = steps_ff + STEP_W'(1);
            end else begin
               mem_we   = '1;
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            mem_addr       = end_ff;
            mem_we.wr_link = 1'b1;
            mem_wlink      = LINK_W'(a_ff);
            res_status_in  = ST_INSERTED;
            res_slot_in    = evict_ff ? home_ff : a_ff;
            fill_in        = fill_ff + STEP_W'(1);
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.slot        = SLOT_W'(res_slot_ff);
               rsp_data_in.comparisons = CMP_W'(res_cmp_ff);
               rsp_data_in.found_tag   = res_tag_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         a_ff         <= '0;
         steps_ff     <= '0;
         cnt_ff       <= '0;
         evict_ff     <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         steps_ff     <= steps_in;
         cnt_ff       <= cnt_in;
         evict_ff     <= evict_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      end_ff        <= end_in;
      home_ff       <= home_in;
      ih_ff         <= ih_in;
      op_ff         <= op_in;
      wk_ff         <= wk_in;
      wt_ff         <= wt_in;
      ek_ff         <= ek_in;
      et_ff         <= et_in;
      enext_ff      <= enext_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_cmp_ff    <= res_cmp_in;
      res_tag_ff    <= res_tag_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= STEP_MAX)
      else $error("occupancy count beyond table size");

   a_no_stray_write : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE || state_ff == S_HOME ||
       state_ff == S_CI_ADDR) |-> !(mem_we.wr_key || mem_we.wr_tag || mem_we.wr_link))
      else $error("slot store written outside a write step");

   a_found_counted : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_status_ff == ST_FOUND) |->
      (res_cmp_ff != '0 && res_cmp_ff <= CNT_MAX + CNT_W'(1)))
      else $error("hit reported with bad comparison count");

   a_insert_room : assert property (@(posedge clock) disable iff (reset)
      (fill_in != fill_ff) |-> (fill_ff < STEP_MAX && state_in == S_DONE))
      else $error("insert completed into a full table");

endmodule

[rtl/coalesced_hash_table_core.sv]
// Coalesced hash table of TABLE_SIZE slots held in one single-port store
// (key, tag, link per slot). One request at a time: req_stall is low only
// while the sequencer is idle. A request with key 0, or an insert into a
// full table, is answered without a remainder or a memory read. Any other
// request first works out its home slot in the remainder unit, then reads
// the store one slot at a time: a search follows the chain from the home
// slot and counts its comparisons; an insert writes a free home slot
// directly, or walks the links to the chain's end, probes past occupied
// slots and links the free slot it finds. In replace mode an occupied home
// slot first has the occupant's own home worked out; evicting a foreign
// occupant adds a scan for its predecessor and one write before it is
// re-chained. After reset the store is cleared slot by slot, during which
// req_stall stays high. The result waits in an output register, so the
// next request is taken while it is pending; a new result is held back
// until the previous one has been taken.
module coalesced_hash_table_core #(
   parameter int TABLE_SIZE = cht_pkg::TABLE_SIZE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_wdata,
   input  logic             req_valid,
   output logic             req_stall,
   input  cht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cht_pkg::rsp_type rsp_data
);
   import cht_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int LINK_W = $clog2(TABLE_SIZE + 1);

   logic              replace_mode_ff;
   logic [IDX_W-1:0]  mem_addr;
   mem_we_type        mem_we;
   logic [KEY_W-1:0]  mem_wkey;
   logic [TAG_W-1:0]  mem_wtag;
   logic [LINK_W-1:0] mem_wlink;
   logic [KEY_W-1:0]  mem_rkey;
   logic [TAG_W-1:0]  mem_rtag;
   logic [LINK_W-1:0] mem_rlink;
   logic              mod_start;
   logic [KEY_W-1:0]  mod_value;
   logic              mod_done;
   logic [IDX_W-1:0]  mod_rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         replace_mode_ff <= 1'b0;
      end else if (csr_we) begin
         replace_mode_ff <= csr_wdata;
      end
   end

   cht_seq #(.TABLE_SIZE(TABLE_SIZE)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .replace_mode (replace_mode_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .mem_addr     (mem_addr),
      .mem_we       (mem_we),
      .mem_wkey     (mem_wkey),
      .mem_wtag     (mem_wtag),
      .mem_wlink    (mem_wlink),
      .mem_rkey     (mem_rkey),
      .mem_rtag     (mem_rtag),
      .mem_rlink    (mem_rlink),
      .mod_start    (mod_start),
      .mod_value    (mod_value),
      .mod_done     (mod_done),
      .mod_rem      (mod_rem)
   );

   cht_mem #(.TABLE_SIZE(TABLE_SIZE)) u_mem (
      .clock (clock),
      .addr  (mem_addr),
      .we    (mem_we),
      .wkey  (mem_wkey),
      .wtag  (mem_wtag),
      .wlink (mem_wlink),
      .rkey  (mem_rkey),
      .rtag  (mem_rtag),
      .rlink (mem_rlink)
   );

   cht_home #(.TABLE_SIZE(TABLE_SIZE)) u_home (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .value (mod_value),
      .done  (mod_done),
      .rem   (mod_rem)
   );

endmodule
